// ----- rtl/aes_block_cipher_core_defines.svh -----
// assertion macros for the aes block cipher core
// no dependencies
`ifndef AES_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES_BLOCK_CIPHER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/aes_pkg.sv -----
// shared types, tables and round functions for the aes block cipher core
// no dependencies
package aes_pkg;

    localparam int NumRoundKeys = 15;
    localparam int KeyIdxW = 6;
    localparam int RoundW = 4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXP_LOAD, ST_EXP_RUN, ST_FETCH, ST_LOAD, ST_ROUND, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CFG_MODE = 3'd0, CFG_KEY0 = 3'd1, CFG_KEY1 = 3'd2, CFG_KEY2 = 3'd3, CFG_KEY3 = 3'd4
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic                exp_load;  // load key words 0..7
        logic                exp_step;  // compute one schedule word
        logic [KeyIdxW-1:0]  exp_idx;
        logic                blk_load;  // load block xored with the first round key
        logic                rnd_en;    // apply one round
        logic                rnd_last;
        logic                rnd_first;
        logic [RoundW-1:0]   key_round; // round key to fetch for next step
    } t_dp_cmd;

    localparam logic [7:0] SBOX [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] REV_SBOX [256] = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] word_subst(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state is bits [127-8i -: 8]
    function automatic logic [127:0] byte_subst(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = inv ? REV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return o;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            b[k] = a[31-8*k -: 8];
            x2[k] = xt(b[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int r = 0; r < 4; r++) begin
            if (inv)
                o[31-8*r -: 8] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
            else
                o[31-8*r -: 8] = x2[r] ^ x2[(r+1)&3] ^ b[(r+1)&3] ^ b[(r+2)&3] ^ b[(r+3)&3];
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
        return o;
    endfunction

endpackage

// ----- rtl/aes_ctrl.sv -----
// controller for the aes core: key schedule sequencing and round counting
// depends on aes_pkg and aes_block_cipher_core_defines.svh
`include "aes_block_cipher_core_defines.svh"
module aes_ctrl import aes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_command,
    input  logic    i_mode,
    input  logic    i_key_write,
    output logic    o_busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);
    t_state r_state, n_state;
    logic r_ready, n_ready;
    logic [KeyIdxW-1:0] r_idx, n_idx;
    logic [RoundW-1:0] r_rnd, n_rnd;
    logic r_dec, n_dec;
    logic [RoundW-1:0] nrounds;
    logic [KeyIdxW-1:0] total;

    assign nrounds = i_mode ? RoundW'(14) : RoundW'(10);
    assign total   = i_mode ? KeyIdxW'(60) : KeyIdxW'(44);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
            r_idx   <= '0;
            r_rnd   <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_idx   <= n_idx;
            r_rnd   <= n_rnd;
            r_dec   <= n_dec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ready = i_key_write ? 1'b0 : r_ready;
        n_idx   = r_idx;
        n_rnd   = r_rnd;
        n_dec   = r_dec;
        o_cmd   = '0;
        o_done  = 1'b0;
        o_busy  = (r_state != ST_IDLE);
        o_cmd.exp_idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                // prefetch the first round key for the incoming command
                o_cmd.key_round = i_command ? nrounds : RoundW'(0);
                if (i_start) begin
                    n_dec   = i_command;
                    n_state = r_ready ? ST_LOAD : ST_EXP_LOAD;
                end
            end
            ST_EXP_LOAD: begin
                o_cmd.exp_load = 1'b1;
                n_idx   = i_mode ? KeyIdxW'(8) : KeyIdxW'(4);
                n_state = ST_EXP_RUN;
            end
            ST_EXP_RUN: begin
                o_cmd.exp_step = 1'b1;
                n_idx = r_idx + KeyIdxW'(1);
                if (r_idx == total - KeyIdxW'(1)) begin
                    n_ready = 1'b1;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // last schedule word is now in the store
                o_cmd.key_round = r_dec ? nrounds : RoundW'(0);
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // add initial key; fetch next round key
                o_cmd.blk_load  = 1'b1;
                o_cmd.key_round = r_dec ? nrounds - RoundW'(1) : RoundW'(1);
                n_rnd   = RoundW'(1);
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.rnd_en    = 1'b1;
                o_cmd.rnd_last  = (r_rnd == nrounds);
                o_cmd.rnd_first = (r_rnd == RoundW'(1));
                if (r_rnd != nrounds)
                    o_cmd.key_round = r_dec ? nrounds - r_rnd - RoundW'(1)
                                            : r_rnd + RoundW'(1);
                n_rnd = r_rnd + RoundW'(1);
                if (r_rnd == nrounds) n_state = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `AES_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |=> r_state == ST_IDLE, "done not followed by idle")
    `AES_ASSERT(a_round_ready, i_clk, i_rst_n, (r_state == ST_ROUND) |-> r_ready, "round without schedule")
    `AES_ASSERT(a_round_bound, i_clk, i_rst_n, (r_state == ST_ROUND) |-> (r_rnd <= nrounds), "round count overrun")
endmodule

// ----- rtl/aes_datapath.sv -----
// datapath for the aes core: key store, schedule unit and round unit
// depends on aes_pkg
module aes_datapath import aes_pkg::*; (
    input  logic          i_clk,
    input  t_dp_cmd       i_cmd,
    input  logic          i_mode,
    input  logic          i_dec,
    input  logic [255:0]  i_key,
    input  logic [127:0]  i_block,
    output logic [127:0]  o_result
);
    // one entry per round key, word 0 of the round in the top lane
    logic [3:0][31:0] r_rk [NumRoundKeys];
    logic [31:0] r_rk_m1 [8];   // last eight schedule words
    logic [7:0] r_rcon;
    logic [127:0] r_state;
    logic [127:0] r_key;        // registered round key read
    logic [31:0] t, w_new, prev, back;
    logic [2:0] pos;
    logic [127:0] s1, s2, s3;

    // schedule word
    assign prev = r_rk_m1[7];
    assign back = i_mode ? r_rk_m1[0] : r_rk_m1[4];
    assign pos  = i_mode ? i_cmd.exp_idx[2:0] : {1'b0, i_cmd.exp_idx[1:0]};
    always_comb begin
        t = prev;
        if (pos == 3'd0)
            t = word_subst({prev[23:0], prev[31:24]}) ^ {r_rcon, 24'h0};
        else if (i_mode && pos == 3'd4)
            t = word_subst(prev);
        w_new = back ^ t;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_load) begin
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
            for (int k = 0; k < 8; k++)
                r_rk_m1[k] <= (i_mode || k >= 4) ? i_key[255-32*(i_mode ? k : (k & 3)) -: 32]
                                                 : 32'h0;
            r_rcon <= 8'h01;
        end else if (i_cmd.exp_step) begin
            r_rk[i_cmd.exp_idx[5:2]][~i_cmd.exp_idx[1:0]] <= w_new;
            for (int k = 0; k < 7; k++) r_rk_m1[k] <= r_rk_m1[k+1];
            r_rk_m1[7] <= w_new;
            if (pos == 3'd0) r_rcon <= xt(r_rcon);
        end
    end

    // round key fetch, registered
    always_ff @(posedge i_clk) r_key <= r_rk[i_cmd.key_round];

    // one round per cycle; inverse round applies mix after key add
    always_comb begin
        if (!i_dec) begin
            s1 = row_rotate(byte_subst(r_state, 1'b0), 1'b0);
            s2 = i_cmd.rnd_last ? s1 : mix_cols(s1, 1'b0);
            s3 = s2 ^ r_key;
        end else begin
            // state holds value before inverse mix of previous round
            s1 = i_cmd.rnd_first ? r_state : mix_cols(r_state, 1'b1);
            s2 = byte_subst(row_rotate(s1, 1'b1), 1'b1);
            s3 = s2 ^ r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) r_state <= i_block ^ r_key;
        else if (i_cmd.rnd_en) r_state <= s3;
    end

    assign o_result = r_state;
endmodule

// ----- rtl/aes_block_cipher_core.sv -----
// AES-128/256 block cipher core. A block is taken when i_start is high and o_busy
// is low; the result appears for one cycle with o_done and cannot be stalled, so
// the receiver must take it then. Blocks run through one shared round unit doing
// one round per cycle. The first block after reset or after any key or mode write
// also runs the key schedule first, one word per cycle. Registers are written
// through i_cfg_we/i_cfg_idx/i_cfg_data.
// depends on aes_pkg, aes_ctrl, aes_datapath
module aes_block_cipher_core import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    logic r_mode;
    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic r_dec;
    logic [127:0] r_block;
    logic key_write;
    logic [127:0] result;
    t_dp_cmd cmd;

    assign key_write = i_cfg_we && (i_cfg_idx <= CFG_KEY3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_KEY0: r_key0 <= i_cfg_data;
                CFG_KEY1: r_key1 <= i_cfg_data;
                CFG_KEY2: r_key2 <= i_cfg_data;
                CFG_KEY3: r_key3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) r_dec <= i_command;
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) r_block <= {i_block_high, i_block_low};
    end

    aes_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_command(i_command),
        .i_mode(r_mode), .i_key_write(key_write), .o_busy(o_busy), .o_done(o_done),
        .o_cmd(cmd)
    );

    aes_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_mode(r_mode), .i_dec(r_dec),
        .i_key({r_key0, r_key1, r_key2, r_key3}), .i_block(r_block), .o_result(result)
    );

    assign o_result_high = result[127:64];
    assign o_result_low  = result[63:0];
endmodule

// ----- tb/sv/aes_block_cipher_core_tb.sv -----
// self-checking testbench for aes_block_cipher_core: directed and random blocks
// checked against an in-bench aes predictor; depends on aes_pkg and the core rtl
`timescale 1ns / 100ps

module aes_block_cipher_core_tb import aes_pkg::*; ();

    localparam logic [2:0] CFG_NONE_LO = 3'd5;  // indexes past the key words
    localparam logic [2:0] CFG_NONE_MID = 3'd6;
    localparam logic [2:0] CFG_NONE_HI = 3'd7;
    localparam bit CMD_ENCRYPT = 1'b0;
    localparam bit CMD_DECRYPT = 1'b1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        bit          cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block_req;

    logic        i_clk, i_rst_n, i_start, i_command, i_cfg_we;
    logic [63:0] i_block_high, i_block_low, i_cfg_data;
    logic [2:0]  i_cfg_idx;
    logic        o_busy, o_done;
    logic [63:0] o_result_high, o_result_low;

    aes_block_cipher_core dut (.*);

    t_block_req   block_queue[$];
    logic [127:0] cipher_out_queue[$];
    logic [7:0]   fwd_sbox[256];
    logic [7:0]   rev_sbox[256];
    logic         aes256_mode;
    logic [63:0]  key_reg[4];
    logic [31:0]  sched[60];
    bit           sched_valid;
    bit           fail_seen;
    bit           took_block;
    int           idle_pct;
    int           quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic void build_sboxes();
        logic [7:0] p, b;
        for (int x = 0; x < 256; x++) begin
            p = 8'h01;
            repeat (254) p = gf_mul(p, x[7:0]);
            b = (x == 0) ? 8'h00 : p;
            p = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
                ^ 8'h63;
            fwd_sbox[x] = p;
            rev_sbox[p] = x[7:0];
        end
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk, total;
        logic [7:0] rcon;
        logic [31:0] t;
        nk = aes256_mode ? 8 : 4;
        total = aes256_mode ? 60 : 44;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++) begin
            sched[2*i] = key_reg[i][63:32];
            sched[2*i+1] = key_reg[i][31:0];
        end
        for (int i = nk; i < total; i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_mul(rcon, 8'h02);
            end else if (nk == 8 && i % 8 == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic logic [127:0] round_key(int r);
        return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
    endfunction

    // one of sub-bytes, shift-rows, mix-columns on a state with byte 0 at the top
    function automatic logic [127:0] round_step(logic [127:0] s, int op, bit inv);
        logic [7:0] a[16];
        logic [7:0] o[16];
        logic [7:0] m[4];
        if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                case (op)
                    0: o[4*c+r] = inv ? rev_sbox[a[4*c+r]] : fwd_sbox[a[4*c+r]];
                    1: o[4*c+r] = a[4*(inv ? ((c + 4 - r) & 3) : ((c + r) & 3)) + r];
                    default: begin
                        o[4*c+r] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            o[4*c+r] ^= gf_mul(a[4*c+k], m[(k + 4 - r) & 3]);
                    end
                endcase
            end
        for (int i = 0; i < 16; i++) s[127-8*i -: 8] = o[i];
        return s;
    endfunction

    function automatic logic [127:0] aes_transform(bit dec, logic [127:0] s);
        int rounds;
        if (!sched_valid) expand_schedule();
        rounds = aes256_mode ? 14 : 10;
        if (!dec) begin
            s ^= round_key(0);
            for (int r = 1; r <= rounds; r++) begin
                s = round_step(round_step(s, 0, 0), 1, 0);
                if (r != rounds) s = round_step(s, 2, 0);
                s ^= round_key(r);
            end
        end else begin
            s ^= round_key(rounds);
            for (int r = rounds - 1; r >= 0; r--) begin
                s = round_step(round_step(s, 1, 1), 0, 1) ^ round_key(r);
                if (r != 0) s = round_step(s, 2, 1);
            end
        end
        return s;
    endfunction

    // monitor: config shadow, expectation push on accept, result check on done
    always @(posedge i_clk) begin
        logic [127:0] want;
        took_block = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                if (cipher_out_queue.size() == 0) begin
                    $display("%0t: unexpected result %h_%h", $time, o_result_high,
                             o_result_low);
                    fail_seen = 1'b1;
                end else begin
                    want = cipher_out_queue.pop_front();
                    if (o_result_high !== want[127:64]) begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 want[127:64], o_result_high);
                        fail_seen = 1'b1;
                    end
                    if (o_result_low !== want[63:0]) begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 want[63:0], o_result_low);
                        fail_seen = 1'b1;
                    end
                end
            end
            if (i_start && !o_busy) begin
                took_block = 1'b1;
                cipher_out_queue.push_back(aes_transform(i_command,
                                                         {i_block_high, i_block_low}));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: aes256_mode = i_cfg_data[0];
                    CFG_KEY0: key_reg[0] = i_cfg_data;
                    CFG_KEY1: key_reg[1] = i_cfg_data;
                    CFG_KEY2: key_reg[2] = i_cfg_data;
                    CFG_KEY3: key_reg[3] = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_idx <= CFG_KEY3) sched_valid = 1'b0;
            end
        end
    end

    // driver: one transaction per accepted start, random sender gaps
    always @(negedge i_clk) begin
        t_block_req req;
        bit next_start;
        next_start = i_start && !took_block;
        if (i_rst_n && !next_start && block_queue.size() != 0
                && $urandom_range(99) >= idle_pct) begin
            req = block_queue.pop_front();
            i_command = req.cmd;
            i_block_high = req.hi;
            i_block_low = req.lo;
            next_start = 1'b1;
        end
        i_start = next_start;
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic push_block(bit cmd, logic [63:0] hi, logic [63:0] lo);
        t_block_req req;
        req.cmd = cmd;
        req.hi = hi;
        req.lo = lo;
        block_queue.push_back(req);
    endtask

    // hold off until every block has come back and the core has gone quiet
    task automatic drain();
        wait (block_queue.size() == 0 && !i_start && cipher_out_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = CMD_ENCRYPT;
        i_block_high = '0;
        i_block_low = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        aes256_mode = 1'b0;
        key_reg = '{default: '0};
        sched_valid = 1'b0;
        fail_seen = 1'b0;
        quiet_cycles = 0;
        idle_pct = 9;
        build_sboxes();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero key after reset, field extremes, both commands
        push_block(CMD_ENCRYPT, '0, '0);
        push_block(CMD_DECRYPT, '0, '0);
        push_block(CMD_ENCRYPT, '1, '1);
        push_block(CMD_DECRYPT, '1, '1);
        push_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        // 128-bit key with junk in the unused upper key words
        write_reg(CFG_KEY0, 64'h0001020304050607);
        write_reg(CFG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(CFG_KEY2, '1);
        write_reg(CFG_KEY3, 64'h5a5a5a5aa5a5a5a5);
        push_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        drain();
        // mode change alone forces a new schedule
        write_reg(CFG_MODE, 64'd1);
        push_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(CMD_DECRYPT, '1, '0);
        drain();
        // unused indexes change nothing
        write_reg(CFG_NONE_LO, '1);
        write_reg(CFG_NONE_HI, '1);
        write_reg(CFG_NONE_MID, '0);
        push_block(CMD_ENCRYPT, '0, '1);
        push_block(CMD_DECRYPT, '0, '1);
        drain();
        write_reg(CFG_KEY0, '1);
        write_reg(CFG_KEY1, '1);
        write_reg(CFG_KEY2, '1);
        write_reg(CFG_KEY3, '1);
        push_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h1);
        push_block(CMD_DECRYPT, 64'h1, 64'h8000000000000000);
        drain();

        for (int p = 0; p < 12; p++) begin
            idle_pct = (p < 4) ? 9 : (p < 8) ? 51 : 0;
            write_reg(CFG_MODE, (p % 3 == 2) ? 64'($urandom_range(1)) : 64'(p[0]));
            for (int k = 0; k < 4; k++)
                if (p < 2 || $urandom_range(3) != 0) write_reg(3'(k + 1), pick_word());
            if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 5)), pick_word());
            for (int n = 0; n < 50; n++)
                push_block($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, pick_word(),
                           pick_word());
            drain();
        end

        if (!fail_seen) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
